// ----- rtl/core/sdwq_pkg.sv -----
// sdwq_pkg: shared constants, request codes and control structs for the
// sorted delay wake-up queue. No dependencies.
package sdwq_pkg;

  // defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int TASK_ID_WIDTH_DEF = 8;

  // fixed field widths
  localparam int TIME_W = 32;
  localparam int OP_W   = 2;

  // request codes
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd1;
  localparam logic [OP_W-1:0] OP_REL_DELAY = 2'd2;
  localparam logic [OP_W-1:0] OP_ABS_DELAY = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch request, advance time on tick
    logic emit_now;  // answer request at once (reply or queue full)
    logic rd_head;   // read queue head
    logic pop;       // head entry due: retire it, emit previous pending
    logic tick_end;  // flush pending wake-up as last of run
    logic rd_ins;    // read entry just below insert position
    logic shift;     // move read entry one place up
    logic place;     // write new entry at insert position
  } sdwq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_tick;
    logic reply_now;
    logic full;
    logic empty;
    logic pos_zero;
    logic entry_due;
    logic entry_later;
  } sdwq_status_t;

endpackage

// ----- rtl/core/sdwq_ram.sv -----
// sdwq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdwq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sdwq_ctrl.sv -----
// sdwq_ctrl: controller state machine for the sorted delay wake-up queue.
// Depends on sdwq_pkg (command and status structs).
module sdwq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  sdwq_pkg::sdwq_status_t st,
  output sdwq_pkg::sdwq_cmd_t    cmd
);
  import sdwq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_TICK_RD  = 3'd1;
  localparam logic [2:0] ST_TICK_CHK = 3'd2;
  localparam logic [2:0] ST_INS_TEST = 3'd3;
  localparam logic [2:0] ST_INS_CHK  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (st.is_tick) begin
            state_nxt = ST_TICK_RD;
          end else if (st.reply_now || st.full) begin
            cmd.emit_now = 1'b1;
          end else begin
            state_nxt = ST_INS_TEST;
          end
        end
      end
      ST_TICK_RD: begin
        if (st.empty) begin
          cmd.tick_end = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.rd_head = 1'b1;
          state_nxt   = ST_TICK_CHK;
        end
      end
      ST_TICK_CHK: begin
        if (st.entry_due) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_TICK_RD;
        end else begin
          cmd.tick_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_INS_TEST: begin
        if (st.pos_zero) begin
          cmd.place = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.rd_ins = 1'b1;
          state_nxt  = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (st.entry_later) begin
          cmd.shift = 1'b1;
          state_nxt = ST_INS_TEST;
        end else begin
          cmd.place = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/sdwq_dp.sv -----
// sdwq_dp: datapath of the sorted delay wake-up queue: tick counter, circular
// sorted queue in RAM, pending wake-up and result registers.
// Depends on sdwq_pkg and sdwq_ram.
module sdwq_dp #(
  parameter int QUEUE_DEPTH   = sdwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_WIDTH = sdwq_pkg::TASK_ID_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdwq_pkg::sdwq_cmd_t            cmd,
  output sdwq_pkg::sdwq_status_t         st,
  input  logic [sdwq_pkg::OP_W-1:0]     in_operation,
  input  logic [TASK_ID_WIDTH-1:0]      in_task_id,
  input  logic [sdwq_pkg::TIME_W-1:0]   in_tick_amount,
  output logic                          out_strobe,
  output logic [TASK_ID_WIDTH-1:0]      out_reply_task,
  output logic [sdwq_pkg::TIME_W-1:0]   out_reply_time,
  output logic                          out_reply_status,
  output logic                          out_last_of_run
);
  import sdwq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TASK_ID_WIDTH + TIME_W;
  localparam logic [AW:0]   DEPTH_EXT  = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT  = CW'(QUEUE_DEPTH);

  // circular index add, both operands below the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_EXT) begin
      s = s - DEPTH_EXT;
    end
    return s[AW-1:0];
  endfunction

  // control registers
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_strobe_r, out_strobe_nxt;

  // payload registers
  logic [TASK_ID_WIDTH-1:0] new_id_r, new_id_nxt;
  logic [TIME_W-1:0]        new_wake_r, new_wake_nxt;
  logic [TASK_ID_WIDTH-1:0] pend_id_r, pend_id_nxt;
  logic [TASK_ID_WIDTH-1:0] out_task_r, out_task_nxt;
  logic [TIME_W-1:0]        out_time_r, out_time_nxt;
  logic                     out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;

  // queue memory
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  logic [TASK_ID_WIDTH-1:0] rd_id;
  logic [TIME_W-1:0]        rd_wake;
  logic [AW-1:0]     pos_a;

  // request decode
  logic [TIME_W:0]   wake_sum;
  logic [TIME_W-1:0] rel_wake;
  logic              reply_now;

  assign wake_sum  = {1'b0, time_r} + {1'b0, in_tick_amount};
  assign rel_wake  = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];
  assign reply_now = (in_operation == OP_QUERY) ||
                     ((in_operation == OP_REL_DELAY) && (in_tick_amount == '0)) ||
                     ((in_operation == OP_ABS_DELAY) && (in_tick_amount <= time_r));

  assign rd_id   = ram_rdata[EW-1:TIME_W];
  assign rd_wake = ram_rdata[TIME_W-1:0];
  assign pos_a   = pos_r[AW-1:0];

  // status to the controller
  always_comb begin
    st.is_tick     = (in_operation == OP_TICK);
    st.reply_now   = reply_now;
    st.full        = (count_r == DEPTH_CNT);
    st.empty       = (count_r == '0);
    st.pos_zero    = (pos_r == '0);
    st.entry_due   = (rd_wake <= time_r);
    st.entry_later = (rd_wake > new_wake_r);
  end

  // memory port control
  assign ram_re    = cmd.rd_head | cmd.rd_ins;
  assign ram_raddr = cmd.rd_head ? head_r : wrap_add(head_r, pos_a - AW'(1));
  assign ram_we    = cmd.shift | cmd.place;
  assign ram_waddr = wrap_add(head_r, pos_a);
  assign ram_wdata = cmd.shift ? ram_rdata : {new_id_r, new_wake_r};

  sdwq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next-state logic for queue bookkeeping and results
  always_comb begin
    time_nxt       = time_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    pos_nxt        = pos_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    new_id_nxt     = new_id_r;
    new_wake_nxt   = new_wake_r;
    out_strobe_nxt = 1'b0;
    out_task_nxt   = out_task_r;
    out_time_nxt   = out_time_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    // request latch
    if (cmd.load) begin
      if (in_operation == OP_TICK) begin
        time_nxt = time_r + TIME_W'(1);
      end
      pos_nxt      = count_r;
      new_id_nxt   = in_task_id;
      new_wake_nxt = (in_operation == OP_REL_DELAY) ? rel_wake : in_tick_amount;
    end

    // immediate answer
    if (cmd.emit_now) begin
      out_strobe_nxt = 1'b1;
      out_task_nxt   = in_task_id;
      out_time_nxt   = time_r;
      out_status_nxt = !reply_now;
      out_last_nxt   = 1'b1;
    end

    // release of a due entry, previous one goes out
    if (cmd.pop) begin
      head_nxt       = wrap_add(head_r, AW'(1));
      count_nxt      = count_r - CW'(1);
      pend_id_nxt    = rd_id;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_strobe_nxt = 1'b1;
        out_task_nxt   = pend_id_r;
        out_time_nxt   = time_r;
        out_status_nxt = 1'b0;
        out_last_nxt   = 1'b0;
      end
    end

    // end of tick run
    if (cmd.tick_end) begin
      pend_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_strobe_nxt = 1'b1;
        out_task_nxt   = pend_id_r;
        out_time_nxt   = time_r;
        out_status_nxt = 1'b0;
        out_last_nxt   = 1'b1;
      end
    end

    // sorted insert steps
    if (cmd.shift) begin
      pos_nxt = pos_r - CW'(1);
    end
    if (cmd.place) begin
      count_nxt = count_r + CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      count_r      <= '0;
      head_r       <= '0;
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      time_r       <= time_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    new_id_r     <= new_id_nxt;
    new_wake_r   <= new_wake_nxt;
    pend_id_r    <= pend_id_nxt;
    out_task_r   <= out_task_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_reply_task   = out_task_r;
  assign out_reply_time   = out_time_r;
  assign out_reply_status = out_status_r;
  assign out_last_of_run  = out_last_r;

endmodule

// ----- rtl/core/sorted_delay_wakeup_queue_top.sv -----
// sorted_delay_wakeup_queue_top: top level of the sorted delay wake-up queue.
// Depends on sdwq_pkg, sdwq_ctrl, sdwq_dp (and sdwq_ram below it).
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   request  | start, busy (take: s & !b)| in_operation, in_task_id,
//            |                           | in_tick_amount
//   result   | out_strobe (one cycle)    | out_reply_task, out_reply_time,
//            |                           | out_reply_status, out_last_of_run
//
// Query, due delay and queue-full requests: result the cycle after the request.
// Tick: the head is read and checked per released entry, and once more when an
// entry stays queued; delay insert: each later entry is read and moved up, then
// the new entry is placed. Each queue step is one read then one compare/write
// on the queue RAM, whose read data is registered.
// Synchronous active-low reset clears the counter and the queue (no clearing
// pass, the RAM holds no state until written). Results cannot be stalled.
module sorted_delay_wakeup_queue_top #(
  parameter int QUEUE_DEPTH   = sdwq_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_WIDTH = sdwq_pkg::TASK_ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sdwq_pkg::OP_W-1:0]   in_operation,
  input  logic [TASK_ID_WIDTH-1:0]    in_task_id,
  input  logic [sdwq_pkg::TIME_W-1:0] in_tick_amount,
  output logic                        out_strobe,
  output logic [TASK_ID_WIDTH-1:0]    out_reply_task,
  output logic [sdwq_pkg::TIME_W-1:0] out_reply_time,
  output logic                        out_reply_status,
  output logic                        out_last_of_run
);
  import sdwq_pkg::*;

  sdwq_cmd_t    cmd;
  sdwq_status_t st;

  sdwq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  sdwq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_tick_amount   (in_tick_amount),
    .out_strobe       (out_strobe),
    .out_reply_task   (out_reply_task),
    .out_reply_time   (out_reply_time),
    .out_reply_status (out_reply_status),
    .out_last_of_run  (out_last_of_run)
  );

  // a query request is answered in the next cycle as a single normal reply
  a_query_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_QUERY)) |=>
      (out_strobe && out_last_of_run && !out_reply_status))
    else $error("query request not answered in next cycle");

  // a wake-up that is not the last of its run comes while the tick is running
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_of_run) |-> busy)
    else $error("non-final wake-up outside a tick run");

  // an entry is never placed into a full queue
  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> !st.full)
    else $error("insert into full queue");

  // queue operations are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_now, cmd.pop, cmd.tick_end, cmd.shift, cmd.place,
              cmd.rd_head, cmd.rd_ins}))
    else $error("conflicting queue commands");

endmodule
